[hw/rtl/klex_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klex_pkg: shared types, constants and lookup functions of the keyword lexer
// Holds the keyword table, the symbol decoder and the step record that
// travels from the classifier to the token emitter.
// ----------------------------------------------------------------------------
package klex_pkg;

  localparam int MAX_WORD_LENGTH = 255;
  localparam int WCNT_W          = $clog2(MAX_WORD_LENGTH + 1);
  localparam int KW_ENTRIES      = 37;
  localparam int KW_CHARS        = 13;
  localparam int KW_LEN_W        = $clog2(KW_CHARS + 1);
  localparam int MASK_W          = 37;
  localparam int LEN_W           = 8;
  localparam int POS_W           = 32;
  localparam int CHAR_W          = 8;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  typedef logic [MASK_W-1:0] kw_mask_t;

  localparam kw_mask_t KW_ALL = {MASK_W{1'b1}};

  // String literals are right aligned: the first character of an entry of
  // length L sits at bits [8*L-1 -: 8].
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_ENTRIES] = '{
    "template", "class", "typename", "namespace", "class", "struct", "enum",
    "friend", "virtual", "override", "explicit", "const", "volatile",
    "mutable", "public", "protected", "private", "auto", "register",
    "static", "extern", {"thread", "_local"}, "void", "bool", "char", "wchar_t",
    {"char", "16_t"}, {"char", "32_t"}, "short", "long", "int", "float", "double",
    "signed", "unsigned", "short", "long"
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_ENTRIES] = '{
    4'd8, 4'd5, 4'd8, 4'd9, 4'd5, 4'd6, 4'd4,
    4'd6, 4'd7, 4'd8, 4'd8, 4'd5, 4'd8,
    4'd7, 4'd6, 4'd9, 4'd7, 4'd4, 4'd8,
    4'd6, 4'd6, 4'd12, 4'd4, 4'd4, 4'd4, 4'd7,
    4'd8, 4'd8, 4'd5, 4'd4, 4'd3, 4'd5, 4'd6,
    4'd6, 4'd8, 4'd5, 4'd4
  };

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_WORD    = 2'd0,
    KIND_KEYWORD = 2'd1,
    KIND_SYMBOL  = 2'd2
  } token_kind_t;

  typedef enum logic [3:0] {
    SYM_ASSIGN = 4'd0,
    SYM_STAR   = 4'd1,
    SYM_AMP    = 4'd2,
    SYM_COLON  = 4'd3,
    SYM_SEMI   = 4'd4,
    SYM_LPAREN = 4'd5,
    SYM_RPAREN = 4'd6,
    SYM_LBRACK = 4'd7,
    SYM_RBRACK = 4'd8,
    SYM_LBRACE = 4'd9,
    SYM_RBRACE = 4'd10,
    SYM_LT     = 4'd11,
    SYM_GT     = 4'd12
  } sym_code_t;

  typedef struct packed {
    logic      hit;
    sym_code_t code;
  } sym_hit_t;

  // One accepted character that produces output: a finished word, a symbol,
  // or both (word first).
  typedef struct packed {
    logic              has_word;
    kw_mask_t          word_mask;
    logic [LEN_W-1:0]  word_len;
    logic [POS_W-1:0]  word_start;
    logic              has_sym;
    sym_code_t         sym_code;
    logic [CHAR_W-1:0] sym_char;
    logic [POS_W-1:0]  sym_pos;
  } tok_step_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic sym_hit_t sym_lookup(input logic [CHAR_W-1:0] c);
    sym_hit_t r;
    r.hit  = 1'b1;
    r.code = SYM_ASSIGN;
    unique case (c)
      "=":     r.code = SYM_ASSIGN;
      "*":     r.code = SYM_STAR;
      "&":     r.code = SYM_AMP;
      ":":     r.code = SYM_COLON;
      ";":     r.code = SYM_SEMI;
      "(":     r.code = SYM_LPAREN;
      ")":     r.code = SYM_RPAREN;
      "[":     r.code = SYM_LBRACK;
      "]":     r.code = SYM_RBRACK;
      "{":     r.code = SYM_LBRACE;
      "}":     r.code = SYM_RBRACE;
      "<":     r.code = SYM_LT;
      ">":     r.code = SYM_GT;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // True when keyword i has character c at offset n.
  function automatic logic kw_keep(input int unsigned i, input logic [WCNT_W-1:0] n,
                                   input logic [CHAR_W-1:0] c);
    logic [8*KW_CHARS-1:0] text;
    int unsigned           len;
    int unsigned           sh;
    text = KW_TEXT[i];
    len  = 32'(KW_LEN[i]);
    sh   = 0;
    if (32'(n) < len) begin
      sh = (len - 1 - 32'(n)) * 8;
      return text[sh +: 8] == c;
    end
    return 1'b0;
  endfunction

endpackage

[hw/rtl/klex_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klex_front: character classifier and keyword narrowing
// Takes one character per cycle while the queue has room, tracks the pending
// word and pushes a step record for each word end and each symbol.
// ----------------------------------------------------------------------------
module klex_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [klex_pkg::CHAR_W-1:0]   ch,
  input  logic                          ch_valid,
  output logic                          ch_stall,
  input  klex_pkg::q_status_t           q_status,
  output logic                          push,
  output klex_pkg::tok_step_t           push_step
);

  logic [klex_pkg::WCNT_W-1:0] word_count;
  logic [klex_pkg::WCNT_W-1:0] word_count_next;
  klex_pkg::kw_mask_t          cand;
  klex_pkg::kw_mask_t          cand_next;
  klex_pkg::kw_mask_t          keep;
  klex_pkg::kw_mask_t          len_hit;
  logic [klex_pkg::POS_W-1:0]  char_pos;
  logic [klex_pkg::POS_W-1:0]  word_start;
  klex_pkg::sym_hit_t          sym;
  logic                        sep;
  logic                        accept;

  assign ch_stall = q_status.full;
  assign accept   = ch_valid && !q_status.full;

  always_comb begin
    sym = klex_pkg::sym_lookup(ch);
    sep = sym.hit || ch == klex_pkg::CH_NUL || ch == klex_pkg::CH_NL ||
          ch == klex_pkg::CH_SPACE;
    for (int unsigned i = 0; i < klex_pkg::KW_ENTRIES; i++) begin
      keep[i]    = klex_pkg::kw_keep(i, word_count, ch);
      len_hit[i] = klex_pkg::WCNT_W'(klex_pkg::KW_LEN[i]) == word_count;
    end
  end

  always_comb begin
    push_step.has_word   = sep && word_count != '0;
    push_step.word_mask  = cand & len_hit;
    push_step.word_len   = klex_pkg::LEN_W'(word_count);
    push_step.word_start = word_start;
    push_step.has_sym    = sym.hit;
    push_step.sym_code   = sym.code;
    push_step.sym_char   = ch;
    push_step.sym_pos    = char_pos;
  end

  assign push = accept && (push_step.has_word || push_step.has_sym);

  always_comb begin
    word_count_next = word_count;
    cand_next       = cand;
    if (sep) begin
      word_count_next = '0;
      cand_next       = klex_pkg::KW_ALL;
    end else begin
      cand_next = cand & keep;
      if (32'(word_count) < klex_pkg::MAX_WORD_LENGTH) begin
        word_count_next = word_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
      cand       <= klex_pkg::KW_ALL;
      char_pos   <= '0;
      word_start <= '0;
    end else if (accept) begin
      word_count <= word_count_next;
      cand       <= cand_next;
      char_pos   <= char_pos + 1'b1;
      if (!sep && word_count == '0) begin
        word_start <= char_pos;
      end
    end
  end

endmodule

[hw/rtl/klex_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klex_queue: step record queue
// Small first-in first-out buffer between classifier and token emitter.
// ----------------------------------------------------------------------------
module klex_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  klex_pkg::tok_step_t  push_step,
  input  logic                 pop,
  output klex_pkg::tok_step_t  head,
  output klex_pkg::q_status_t  q_status
);

  klex_pkg::tok_step_t          slots [klex_pkg::QDEPTH];
  logic [klex_pkg::QPTR_W-1:0]  wr_ptr;
  logic [klex_pkg::QPTR_W-1:0]  rd_ptr;
  logic [klex_pkg::QCNT_W-1:0]  fill;

  assign head           = slots[rd_ptr];
  assign q_status.full  = fill == klex_pkg::QCNT_W'(klex_pkg::QDEPTH);
  assign q_status.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/klex_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klex_back: token emitter
// Holds one step record in an output register and hands out its word token,
// its symbol token, or both with the word first.
// ----------------------------------------------------------------------------
module klex_back (
  input  logic                         clk,
  input  logic                         rst,
  input  klex_pkg::q_status_t          q_status,
  input  klex_pkg::tok_step_t          head,
  output logic                         pop,
  output logic                         tok_valid,
  input  logic                         tok_stall,
  output logic [1:0]                   token_kind,
  output logic [klex_pkg::MASK_W-1:0]  keyword_mask,
  output logic [3:0]                   symbol_code,
  output logic [klex_pkg::CHAR_W-1:0]  symbol_char,
  output logic [klex_pkg::LEN_W-1:0]   word_length,
  output logic [klex_pkg::POS_W-1:0]   start_position,
  output logic                         last
);

  klex_pkg::tok_step_t cur;
  logic                cur_valid;
  logic                xfer;
  logic                split;
  logic                finish;

  assign tok_valid = cur_valid;
  assign xfer      = cur_valid && !tok_stall;
  // Word and symbol from the same character: the word goes out first.
  assign split     = cur.has_word && cur.has_sym;
  assign finish    = xfer && !split;
  assign pop       = (!cur_valid || finish) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (finish) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (xfer && split) begin
      cur.has_word <= 1'b0;
    end
  end

  always_comb begin
    if (cur.has_word) begin
      token_kind     = (cur.word_mask != '0) ? klex_pkg::KIND_KEYWORD : klex_pkg::KIND_WORD;
      keyword_mask   = cur.word_mask;
      symbol_code    = '0;
      symbol_char    = '0;
      word_length    = cur.word_len;
      start_position = cur.word_start;
      last           = !cur.has_sym;
    end else begin
      token_kind     = klex_pkg::KIND_SYMBOL;
      keyword_mask   = '0;
      symbol_code    = cur.sym_code;
      symbol_char    = cur.sym_char;
      word_length    = klex_pkg::LEN_W'(1);
      start_position = cur.sym_pos;
      last           = 1'b1;
    end
  end

endmodule

[hw/rtl/keyword_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_lexer: character stream tokenizer with keyword matching
// Path: a token's record goes through a queue slot, then the output register,
//   before the token is presented; a stalled output can hold it in the queue.
// Throughput: one character per cycle; a word ended by a symbol gives two
//   tokens over two output transfers. Input stalls only on a full queue.
// Reset: synchronous; clears word state, position and queue, no clear pass.
// ----------------------------------------------------------------------------
module keyword_lexer (
  input  logic                         clk,
  input  logic                         rst,
  // character input
  input  logic [klex_pkg::CHAR_W-1:0]  ch,
  input  logic                         ch_valid,
  output logic                         ch_stall,
  // token output
  output logic                         tok_valid,
  input  logic                         tok_stall,
  output logic [1:0]                   token_kind,
  output logic [klex_pkg::MASK_W-1:0]  keyword_mask,
  output logic [3:0]                   symbol_code,
  output logic [klex_pkg::CHAR_W-1:0]  symbol_char,
  output logic [klex_pkg::LEN_W-1:0]   word_length,
  output logic [klex_pkg::POS_W-1:0]   start_position,
  output logic                         last
);

  // Step records move from the classifier through a short queue, so a
  // stalled consumer does not stop the character stream until it fills.
  klex_pkg::q_status_t q_status;
  klex_pkg::tok_step_t push_step;
  klex_pkg::tok_step_t head;
  logic                push;
  logic                pop;

  // Front: classify each character, narrow the keyword candidates, and
  // push a record whenever a word ends or a symbol arrives.
  klex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .ch_valid  (ch_valid),
    .ch_stall  (ch_stall),
    .q_status  (q_status),
    .push      (push),
    .push_step (push_step)
  );

  // Queue: decouples the two sides.
  klex_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_step (push_step),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // Back: unpack each record into one or two token transfers, word first.
  klex_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .head           (head),
    .pop            (pop),
    .tok_valid      (tok_valid),
    .tok_stall      (tok_stall),
    .token_kind     (token_kind),
    .keyword_mask   (keyword_mask),
    .symbol_code    (symbol_code),
    .symbol_char    (symbol_char),
    .word_length    (word_length),
    .start_position (start_position),
    .last           (last)
  );

endmodule
